/* hdl/bounded_double_ended_queue_defines.svh */
// Assertion helpers shared by the queue's modules.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Implication property checked out of reset.
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define BDQ_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/bdq_pkg.sv */
package bdq_pkg;

  // Store geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int CMD_W  = 3;

  // Reported for both ends when nothing is held, and the capacity out of reset
  localparam logic signed [DATA_W-1:0] EMPTY_WORD = -1;
  localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(DEPTH);

  // Command codes; unused codes behave as peek
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic [CNT_W-1:0]         occupancy;
    logic                     empty_flag;
    logic                     full_flag;
    logic                     rejected;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // input transfer this cycle: update pointers, write store
    logic read_en;  // read front and rear entries
    logic load;     // load result register
  } ctl_t;

endpackage

/* hdl/bounded_double_ended_queue.sv */
// Bounded deque of 32-bit words over a 16-entry ring store.
// Each input transfer is followed by a store read and then a result load, which waits while the output stalls.
// A new item is taken only once the result of the previous one has been loaded.
// A pending result may wait in the output register while the next item is taken.
// Reset (synchronous, rst_n low): queue empty, front at 0, capacity 16.
module bounded_double_ended_queue import bdq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  ctl_t ctl;

  // Capacity writes are always taken
  assign cfg_ready = 1'b1;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  bdq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

/* hdl/bdq_ram.sv */
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* hdl/bdq_ctrl.sv */
`include "bounded_double_ended_queue_defines.svh"

module bdq_ctrl import bdq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ctl_t ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       load;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // Result register is free when empty or being drained this cycle
  assign load     = (state_r == ST_LOAD) && (!out_valid_r || out_ready);

  assign ctl.accept  = accept;
  assign ctl.read_en = (state_r == ST_READ);
  assign ctl.load    = load;
  assign out_valid   = out_valid_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BDQ_ASSERT(a_read_then_load, clk, rst_n, (state_r == ST_READ) |=> (state_r == ST_LOAD), "read not followed by load")
  `BDQ_ASSERT(a_hold_on_stall, clk, rst_n, (state_r == ST_LOAD && out_valid_r && !out_ready) |=> (state_r == ST_LOAD), "result overwritten while stalled")

endmodule

/* hdl/bdq_datapath.sv */
`include "bounded_double_ended_queue_defines.svh"

module bdq_datapath import bdq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             ctl,
  input  in_t              in_data,
  input  logic             cfg_valid,
  input  logic [CAP_W-1:0] cfg_data,
  output out_t             out_data
);

  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic              rej_r, rej_nxt;
  out_t              out_r;
  logic [CAP_W-1:0]  eff_cap;
  logic              full, empty;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  rear_addr;
  logic [DATA_W-1:0] rd_front, rd_rear;

  // Ring position base + off, wrapped once
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W+1-IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  // Capacity saturates at the store depth
  assign eff_cap   = (cap_r > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_r;
  assign full      = CAP_W'(count_r) >= eff_cap;
  assign empty     = (count_r == '0);
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - 1'b1;
  assign rear_addr = ring_pos(front_r, count_r - 1'b1);

  // Command decode and pointer update
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    rej_nxt   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = front_dec;
    case (in_data.cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          rej_nxt = 1'b1;
        end else begin
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
          wr_en     = ctl.accept;
          wr_addr   = front_dec;
        end
      end
      CMD_PUSH_REAR: begin
        if (full) begin
          rej_nxt = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
          wr_en     = ctl.accept;
          wr_addr   = ring_pos(front_r, count_r);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          rej_nxt = 1'b1;
        end else begin
          front_nxt = ring_pos(front_r, CNT_W'(1));
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_POP_REAR: begin
        if (empty) begin
          rej_nxt = 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        // peek and unused codes leave the queue alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      if (ctl.accept) begin
        front_r <= front_nxt;
        count_r <= count_nxt;
      end
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      rej_r <= rej_nxt;
    end
    if (ctl.load) begin
      out_r.front_value <= empty ? EMPTY_WORD : $signed(rd_front);
      out_r.rear_value  <= empty ? EMPTY_WORD : $signed(rd_rear);
      out_r.occupancy   <= count_r;
      out_r.empty_flag  <= empty;
      out_r.full_flag   <= full;
      out_r.rejected    <= rej_r;
    end
  end

  assign out_data = out_r;

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (in_data.push_value),
    .rd_en     (ctl.read_en),
    .rd_addr_a (front_r),
    .rd_addr_b (rear_addr),
    .rd_data_a (rd_front),
    .rd_data_b (rd_rear)
  );

  `BDQ_NEVER(a_count_bound, clk, rst_n, count_r > CNT_W'(DEPTH), "occupancy beyond store depth")
  `BDQ_ASSERT(a_reject_holds, clk, rst_n, (ctl.accept && rej_nxt) |=> ($stable(count_r) && $stable(front_r)), "rejected command changed the queue")

endmodule
